// ===== sv/rarp_pkg.sv =====
// Shared types and constants for the RESP array request parser.
package rarp_pkg;

  // Width of the count arithmetic; values are capped at the largest it holds.
  localparam int unsigned CountWidth = 32;
  localparam logic [63:0] WidthMax =
    (CountWidth >= 64) ? {64{1'b1}} : ((64'd1 << (CountWidth % 64)) - 64'd1);

  localparam int unsigned NumW = 31;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Error codes reported in the value field.
  localparam logic [NumW-1:0] ErrExpStar   = 31'd1;
  localparam logic [NumW-1:0] ErrBadDigit  = 31'd2;
  localparam logic [NumW-1:0] ErrExpDollar = 31'd3;
  localparam logic [NumW-1:0] ErrExpCrLf   = 31'd4;
  localparam logic [NumW-1:0] ErrCountBig  = 31'd5;
  localparam logic [NumW-1:0] ErrLenBig    = 31'd6;

  localparam logic [NumW-1:0] MaxElementsReset   = 31'd1048576;
  localparam logic [NumW-1:0] MaxBulkLengthReset = 31'd536870912;

  typedef enum logic [2:0] {
    KIND_ARRAY   = 3'd0,
    KIND_BULK    = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8
  } phase_e;

  // Register addresses (byte address bit 2 selects the register).
  localparam logic REG_MAX_ELEMENTS    = 1'b0;
  localparam logic REG_MAX_BULK_LENGTH = 1'b1;

  typedef struct packed {
    logic [NumW-1:0] max_elements;
    logic [NumW-1:0] max_bulk_length;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [NumW-1:0] value;
    logic [NumW-1:0] element_index;
    logic            last_of_element;
    logic            command_end;
  } result_t;

endpackage

// ===== sv/rarp_cfg.sv =====
// APB register file holding the two parser limits.
module rarp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rarp_pkg::cfg_t     cfg_o
);
  import rarp_pkg::*;

  logic [NumW-1:0] max_elements_q;
  logic [NumW-1:0] max_bulk_length_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elements_q    <= MaxElementsReset;
      max_bulk_length_q <= MaxBulkLengthReset;
    end else if (wr_en) begin
      if (paddr[2] == REG_MAX_ELEMENTS) begin
        max_elements_q <= pwdata[NumW-1:0];
      end else begin
        max_bulk_length_q <= pwdata[NumW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_BULK_LENGTH) begin
      prdata = {1'b0, max_bulk_length_q};
    end else begin
      prdata = {1'b0, max_elements_q};
    end
  end

  assign cfg_o.max_elements    = max_elements_q;
  assign cfg_o.max_bulk_length = max_bulk_length_q;

endmodule

// ===== sv/rarp_parse.sv =====
// Parser FSM: one byte per cycle on fire_i, zero or one result per byte.
module rarp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  input  logic               restart_i,
  input  rarp_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output rarp_pkg::result_t  res_o
);
  import rarp_pkg::*;

  phase_e          phase_q, phase_d, phase_e_cur;
  logic [NumW-1:0] acc_q, acc_d, acc_cur;
  logic [NumW-1:0] el_left_q, el_left_d, el_left_cur;
  logic [NumW-1:0] pay_left_q, pay_left_d, pay_left_cur;
  logic [NumW-1:0] cnt_q, cnt_d, cnt_cur;

  logic [NumW-1:0] limit;
  logic [NumW-1:0] cap;
  logic [NumW+3:0] acc_next;
  logic [NumW-1:0] pay_dec;
  logic [NumW-1:0] el_dec;
  logic            is_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      acc_q      <= '0;
      el_left_q  <= '0;
      pay_left_q <= '0;
      cnt_q      <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      el_left_q  <= el_left_d;
      pay_left_q <= pay_left_d;
      cnt_q      <= cnt_d;
    end
  end

  // A restart clears the state before the byte is looked at.
  assign phase_e_cur  = restart_i ? PH_IDLE : phase_q;
  assign acc_cur      = restart_i ? '0 : acc_q;
  assign el_left_cur  = restart_i ? '0 : el_left_q;
  assign pay_left_cur = restart_i ? '0 : pay_left_q;
  assign cnt_cur      = restart_i ? '0 : cnt_q;

  // The accumulator never exceeds the cap, so only the new value is compared.
  assign limit    = (phase_e_cur == PH_LEN) ? cfg_i.max_bulk_length : cfg_i.max_elements;
  assign cap      = ({33'd0, limit} < WidthMax) ? limit : WidthMax[NumW-1:0];
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign acc_next = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                  + {31'd0, byte_i[3:0] - ChZero[3:0]};
  assign pay_dec  = pay_left_cur - 31'd1;
  assign el_dec   = el_left_cur - 31'd1;

  always_comb begin
    phase_d    = phase_e_cur;
    acc_d      = acc_cur;
    el_left_d  = el_left_cur;
    pay_left_d = pay_left_cur;
    cnt_d      = cnt_cur;

    res_valid_o           = 1'b0;
    res_o.kind            = KIND_ERROR;
    res_o.value           = '0;
    res_o.element_index   = cnt_cur;
    res_o.last_of_element = 1'b0;
    res_o.command_end     = 1'b0;

    case (phase_e_cur)
      PH_IDLE: begin
        if (byte_i != ChStar) begin
          res_valid_o = 1'b1;
          res_o.value = ErrExpStar;
        end else begin
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (byte_i == ChCr) begin
          phase_d = (phase_e_cur == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else if (!is_digit) begin
          res_valid_o = 1'b1;
          res_o.value = ErrBadDigit;
        end else if (acc_next > {4'd0, cap}) begin
          res_valid_o = 1'b1;
          res_o.value = (phase_e_cur == PH_COUNT) ? ErrCountBig : ErrLenBig;
        end else begin
          acc_d = acc_next[NumW-1:0];
        end
      end
      PH_COUNT_LF: begin
        res_valid_o = 1'b1;
        if (byte_i != ChLf) begin
          res_o.value = ErrExpCrLf;
        end else begin
          res_o.kind          = KIND_ARRAY;
          res_o.value         = acc_cur;
          res_o.element_index = '0;
          acc_d               = '0;
          el_left_d           = acc_cur;
          cnt_d               = '0;
          phase_d             = PH_DOLLAR;
          if (acc_cur == '0) begin
            res_o.command_end = 1'b1;
          end
        end
      end
      PH_DOLLAR: begin
        if (byte_i != ChDollar) begin
          res_valid_o = 1'b1;
          res_o.value = ErrExpDollar;
        end else begin
          acc_d   = '0;
          phase_d = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        res_valid_o = 1'b1;
        if (byte_i != ChLf) begin
          res_o.value = ErrExpCrLf;
        end else begin
          res_o.kind  = KIND_BULK;
          res_o.value = acc_cur;
          acc_d       = '0;
          pay_left_d  = acc_cur;
          phase_d     = (acc_cur == '0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o           = 1'b1;
        res_o.kind            = KIND_PAYLOAD;
        res_o.value           = {23'd0, byte_i};
        res_o.last_of_element = (pay_dec == '0);
        pay_left_d            = pay_dec;
        if (pay_dec == '0) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (byte_i != ChCr) begin
          res_valid_o = 1'b1;
          res_o.value = ErrExpCrLf;
        end else begin
          phase_d = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        res_valid_o = 1'b1;
        if (byte_i != ChLf) begin
          res_o.value = ErrExpCrLf;
        end else begin
          res_o.kind  = KIND_DONE;
          el_left_d   = el_dec;
          if (el_dec == '0) begin
            res_o.command_end = 1'b1;
          end else begin
            cnt_d   = cnt_cur + 31'd1;
            phase_d = PH_DOLLAR;
          end
        end
      end
      default: begin
        res_valid_o = 1'b1;
        res_o.value = ErrExpStar;
      end
    endcase

    // Errors and completed commands return everything to idle.
    if (res_valid_o && ((res_o.kind == KIND_ERROR) || res_o.command_end)) begin
      phase_d    = PH_IDLE;
      acc_d      = '0;
      el_left_d  = '0;
      pay_left_d = '0;
      cnt_d      = '0;
    end
  end

endmodule

// ===== sv/resp_array_request_parser.sv =====
// Top level of the RESP array request parser: input register, parser, result register.
// Each byte's result is computed from the input register into the result register.
// Throughput: one byte per cycle while the result register is not stalled, set by the
// combinational parser step between the input register and the result register.
// Reset: rst_ni is asynchronous and active low; it empties both registers,
// returns the parser to idle and loads the limit registers with their defaults.
module resp_array_request_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [30:0]        value_o,
  output logic [30:0]        element_index_o,
  output logic               last_of_element_o,
  output logic               command_end_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rarp_pkg::*;

  cfg_t      cfg;
  result_t   res;
  logic      res_valid;
  logic      fire;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       restart_q;
  logic       out_valid_q;
  result_t    out_q;

  // The held byte is consumed when the result register is free or draining.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q    <= data_byte_i;
      restart_q <= restart_i;
    end
  end

  rarp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rarp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (byte_q),
    .restart_i   (restart_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign value_o           = out_q.value;
  assign element_index_o   = out_q.element_index;
  assign last_of_element_o = out_q.last_of_element;
  assign command_end_o     = out_q.command_end;

endmodule

// ===== sv/rarp_checker.sv =====
// Port-level checks for the RESP array request parser, bound to the top level.
module rarp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [30:0] value_o,
  input logic        last_of_element_o,
  input logic        command_end_o
);
  import rarp_pkg::*;

  // A stalled result transaction is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(value_o))
    else $error("result changed while stalled");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_element_o |-> kind_o == KIND_PAYLOAD)
    else $error("last_of_element on a non-payload result");

  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_end_o |-> kind_o == KIND_ARRAY || kind_o == KIND_DONE)
    else $error("command_end on an unexpected result kind");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |->
      value_o >= ErrExpStar && value_o <= ErrLenBig && !command_end_o)
    else $error("error result with a bad code");

  a_done_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |-> value_o == '0)
    else $error("element done with a non-zero value");

endmodule

bind resp_array_request_parser rarp_checker u_rarp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .kind_o            (kind_o),
  .value_o           (value_o),
  .last_of_element_o (last_of_element_o),
  .command_end_o     (command_end_o)
);
